>>> hdl/mibd_pkg.sv
package mibd_pkg;

  localparam logic [5:0] OP_REGMEM = 6'b100010;
  localparam logic [3:0] OP_IMMREG = 4'b1011;
  localparam logic [1:0] MOD_REG   = 2'b11;
  localparam logic [1:0] MOD_DISP8 = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_NODISP = 2'b00;
  localparam logic [2:0] RM_DIRECT = 3'b110;

  typedef enum logic [1:0] {
    KIND_REGMEM = 2'd0,
    KIND_IMMREG = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               wide;
    logic               reg_is_dest;
    logic [1:0]         mode;
    logic [2:0]         reg_code;
    logic [2:0]         rm_code;
    logic signed [15:0] displacement;
    logic               direct_address;
    logic [15:0]        immediate;
    logic [7:0]         lead_byte;
  } result_t;

  function automatic result_t mk_regmem(logic [7:0] first, logic [7:0] second,
                                        logic [15:0] disp);
    result_t r;
    r = '0;
    r.kind           = KIND_REGMEM;
    r.wide           = first[0];
    r.reg_is_dest    = first[1];
    r.mode           = second[7:6];
    r.reg_code       = second[5:3];
    r.rm_code        = second[2:0];
    r.displacement   = disp;
    r.direct_address = (second[7:6] == MOD_NODISP) && (second[2:0] == RM_DIRECT);
    r.lead_byte      = first;
    return r;
  endfunction

  function automatic result_t mk_immreg(logic [7:0] first, logic [15:0] imm);
    result_t r;
    r = '0;
    r.kind        = KIND_IMMREG;
    r.wide        = first[3];
    r.reg_is_dest = 1'b1;
    r.reg_code    = first[2:0];
    r.immediate   = imm;
    r.lead_byte   = first;
    return r;
  endfunction

  function automatic result_t mk_unknown(logic [7:0] b);
    result_t r;
    r = '0;
    r.kind      = KIND_UNKNOWN;
    r.lead_byte = b;
    return r;
  endfunction

endpackage

>>> hdl/mov_instruction_byte_decoder_core.sv
// The code byte that completes a result is first held in the input register and is then
// decoded into the result register, where that result stands.
// Throughput: one code byte per cycle; the input register is refilled in the same
// cycle that its byte is decoded, so only a stalled result register holds it back.
// Reset (synchronous, rst_n low) returns the decoder to waiting for a leading byte
// and empties both the input and the result register.
module mov_instruction_byte_decoder_core
  import mibd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // wide, reg_is_dest, mode[1:0], reg_code[2:0],
                                  // rm_code[2:0], displacement[15:0], direct_address,
                                  // immediate[15:0], lead_byte[7:0], zero pad
  output logic [1:0]  out_tuser   // [1:0] kind
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;
  logic       out_free;
  logic       advance;
  logic       dec_valid;
  result_t    dec_res;

  assign out_free  = !out_valid_r || out_tready;
  // A byte in the input register is decoded once the result register can take
  // whatever it produces.
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || advance;

  mibd_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .code_byte (in_byte_r),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_valid) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {5'd0,
                       out_res_r.lead_byte,
                       out_res_r.immediate,
                       out_res_r.direct_address,
                       out_res_r.displacement,
                       out_res_r.rm_code,
                       out_res_r.reg_code,
                       out_res_r.mode,
                       out_res_r.reg_is_dest,
                       out_res_r.wide};

endmodule

>>> hdl/mibd_decoder.sv
module mibd_decoder
  import mibd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] code_byte,
  output logic       res_valid,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_DATA_LO = 3'd4,
    PH_DATA_HI = 3'd5
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [7:0] low_r, low_nxt;
  logic [1:0] left_r, left_nxt;

  always_comb begin
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    low_nxt    = low_r;
    left_nxt   = left_r;
    res_valid  = 1'b0;
    res        = '0;
    unique case (phase_r)
      PH_MODRM: begin
        second_nxt = code_byte;
        if (code_byte[7:6] == MOD_DISP8) begin
          left_nxt  = 2'd1;
          phase_nxt = PH_DISP_LO;
        end else if (code_byte[7:6] == MOD_DISP16 ||
                     (code_byte[7:6] == MOD_NODISP && code_byte[2:0] == RM_DIRECT)) begin
          left_nxt  = 2'd2;
          phase_nxt = PH_DISP_LO;
        end else begin
          phase_nxt = PH_FIRST;
          res_valid = 1'b1;
          res       = mk_regmem(first_r, code_byte, 16'd0);
        end
      end
      PH_DISP_LO: begin
        low_nxt = code_byte;
        if (left_r == 2'd1) begin
          left_nxt  = 2'd0;
          phase_nxt = PH_FIRST;
          res_valid = 1'b1;
          res       = mk_regmem(first_r, second_r, {{8{code_byte[7]}}, code_byte});
        end else begin
          left_nxt  = 2'd1;
          phase_nxt = PH_DISP_HI;
        end
      end
      PH_DISP_HI: begin
        left_nxt  = 2'd0;
        phase_nxt = PH_FIRST;
        res_valid = 1'b1;
        res       = mk_regmem(first_r, second_r, {code_byte, low_r});
      end
      PH_DATA_LO: begin
        if (!first_r[3]) begin
          phase_nxt = PH_FIRST;
          res_valid = 1'b1;
          res       = mk_immreg(first_r, {8'd0, code_byte});
        end else begin
          low_nxt   = code_byte;
          phase_nxt = PH_DATA_HI;
        end
      end
      PH_DATA_HI: begin
        phase_nxt = PH_FIRST;
        res_valid = 1'b1;
        res       = mk_immreg(first_r, {code_byte, low_r});
      end
      default: begin
        // Waiting for a leading byte; unused phase codes land here as well.
        phase_nxt = PH_FIRST;
        left_nxt  = 2'd0;
        if (code_byte[7:2] == OP_REGMEM) begin
          first_nxt = code_byte;
          phase_nxt = PH_MODRM;
        end else if (code_byte[7:4] == OP_IMMREG) begin
          first_nxt = code_byte;
          phase_nxt = PH_DATA_LO;
        end else begin
          res_valid = 1'b1;
          res       = mk_unknown(code_byte);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      first_r  <= '0;
      second_r <= '0;
      low_r    <= '0;
      left_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      low_r    <= low_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

>>> test/mov_instruction_byte_decoder_core_tb.sv
module mov_instruction_byte_decoder_core_tb;
  import mibd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int BYTES_TARGET = 1450;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 900;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [2:0] {
    WAIT_LEAD,
    WAIT_MODRM,
    WAIT_DISP_LO,
    WAIT_DISP_HI,
    WAIT_DATA_LO,
    WAIT_DATA_HI
  } dec_phase_t;

  typedef struct {
    logic [7:0] code;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  // Decoder state as the block should hold it.
  dec_phase_t  dec_phase = WAIT_LEAD;
  logic [7:0]  lead_held = '0;
  logic [7:0]  modrm_held = '0;
  logic [7:0]  low_held = '0;
  logic [1:0]  disp_left = '0;

  result_t     decoded_q[$];
  stim_row_t   rows[$];
  bit          calm = 1'b0;
  int          errors = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          kind_seen[3] = '{0, 0, 0};
  int          cycle_count = 0;

  mov_instruction_byte_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  function automatic result_t plain_result(kind_t k, logic w, logic d, logic [1:0] md,
                                           logic [2:0] rg, logic [2:0] rm,
                                           logic [7:0] lead);
    result_t r;
    r = '0;
    r.kind        = k;
    r.wide        = w;
    r.reg_is_dest = d;
    r.mode        = md;
    r.reg_code    = rg;
    r.rm_code     = rm;
    r.lead_byte   = lead;
    return r;
  endfunction

  function automatic result_t regmem_result(logic [15:0] disp);
    result_t r;
    r = plain_result(KIND_REGMEM, lead_held[0], lead_held[1], modrm_held[7:6],
                     modrm_held[5:3], modrm_held[2:0], lead_held);
    r.displacement   = disp;
    r.direct_address = (modrm_held[7:6] == MOD_NODISP) && (modrm_held[2:0] == RM_DIRECT);
    return r;
  endfunction

  function automatic result_t immediate_result(logic [15:0] data);
    result_t r;
    r = plain_result(KIND_IMMREG, lead_held[3], 1'b1, 2'd0, lead_held[2:0], 3'd0,
                     lead_held);
    r.immediate = data;
    return r;
  endfunction

  // Advances the decoder by one code byte; returns 1 when the byte completes a result.
  function automatic bit decode_byte(input logic [7:0] b, output result_t r);
    logic [1:0] md;
    logic [2:0] rm;
    r  = '0;
    md = b[7:6];
    rm = b[2:0];
    case (dec_phase)
      WAIT_MODRM: begin
        modrm_held = b;
        if (md == MOD_DISP8) begin
          disp_left = 2'd1;
        end else if (md == MOD_DISP16 || (md == MOD_NODISP && rm == RM_DIRECT)) begin
          disp_left = 2'd2;
        end else begin
          disp_left = 2'd0;
        end
        if (disp_left == 2'd0) begin
          dec_phase = WAIT_LEAD;
          r = regmem_result(16'h0000);
          return 1'b1;
        end
        dec_phase = WAIT_DISP_LO;
        return 1'b0;
      end
      WAIT_DISP_LO: begin
        low_held = b;
        if (disp_left == 2'd1) begin
          disp_left = 2'd0;
          dec_phase = WAIT_LEAD;
          r = regmem_result({{8{b[7]}}, b});
          return 1'b1;
        end
        disp_left = 2'd1;
        dec_phase = WAIT_DISP_HI;
        return 1'b0;
      end
      WAIT_DISP_HI: begin
        disp_left = 2'd0;
        dec_phase = WAIT_LEAD;
        r = regmem_result({b, low_held});
        return 1'b1;
      end
      WAIT_DATA_LO: begin
        if (!lead_held[3]) begin
          dec_phase = WAIT_LEAD;
          r = immediate_result({8'h00, b});
          return 1'b1;
        end
        low_held  = b;
        dec_phase = WAIT_DATA_HI;
        return 1'b0;
      end
      WAIT_DATA_HI: begin
        dec_phase = WAIT_LEAD;
        r = immediate_result({b, low_held});
        return 1'b1;
      end
      default: begin
        dec_phase = WAIT_LEAD;
        disp_left = 2'd0;
        if (b[7:2] == OP_REGMEM) begin
          lead_held = b;
          dec_phase = WAIT_MODRM;
          return 1'b0;
        end
        if (b[7:4] == OP_IMMREG) begin
          lead_held = b;
          dec_phase = WAIT_DATA_LO;
          return 1'b0;
        end
        r.kind      = KIND_UNKNOWN;
        r.lead_byte = b;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic add_row(input logic [7:0] c, input bit typed = 1'b0,
                         input result_t want = '0);
    rows.push_back('{c, typed, want});
  endtask

  // Offers one code byte until the block takes it, then books the expected result.
  // Once offered, the byte stays on the bus with tvalid high until it is accepted.
  // A typed expectation replaces the predicted one, while the decoder state still advances.
  task automatic push_byte(input logic [7:0] b, input bit typed, input result_t want);
    bit      taken;
    bit      offered;
    result_t r;
    taken   = 1'b0;
    offered = 1'b0;
    while (!taken) begin
      @(negedge clk);
      calm = (bytes_sent >= CALM_FIRST) && (bytes_sent < CALM_LAST);
      if (!offered && !calm && $urandom_range(99) < 38) begin
        in_tvalid <= 1'b0;
      end else begin
        offered = 1'b1;
        in_tvalid <= 1'b1;
        in_tdata  <= b;
      end
      @(posedge clk);
      if (in_tvalid && in_tready) begin
        taken = 1'b1;
        bytes_sent++;
        if (decode_byte(b, r)) begin
          decoded_q.push_back(typed ? want : r);
        end else if (typed) begin
          report($sformatf("table row for byte %h expects a result the decoder never makes",
                           b));
        end
      end
    end
  endtask

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser < 2'd3) begin
        kind_seen[out_tuser]++;
      end
      if (decoded_q.size() == 0) begin
        report($sformatf("result kind %0d lead %h with no request pending",
                         out_tuser, out_tdata[50:43]));
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 16'(out_tuser), 16'(want.kind));
        check_field("wide", 16'(out_tdata[0]), 16'(want.wide));
        check_field("reg_is_dest", 16'(out_tdata[1]), 16'(want.reg_is_dest));
        check_field("mode", 16'(out_tdata[3:2]), 16'(want.mode));
        check_field("reg_code", 16'(out_tdata[6:4]), 16'(want.reg_code));
        check_field("rm_code", 16'(out_tdata[9:7]), 16'(want.rm_code));
        check_field("displacement", out_tdata[25:10], want.displacement);
        check_field("direct_address", 16'(out_tdata[26]), 16'(want.direct_address));
        check_field("immediate", out_tdata[42:27], want.immediate);
        check_field("lead_byte", 16'(out_tdata[50:43]), 16'(want.lead_byte));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, decoded_q.size());
    $display("mov_instruction_byte_decoder_core_tb failed");
    $finish;
  end

  initial begin
    logic [7:0] stream_q[$];
    logic [7:0] lead;
    logic [7:0] modrm;
    int         pick;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    out_tready = 1'b0;
    rst_n      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(8'h00, 1'b1, plain_result(KIND_UNKNOWN, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 8'h00));
    add_row(8'hFF, 1'b1, plain_result(KIND_UNKNOWN, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 8'hFF));
    add_row(8'h88);
    add_row(8'hC0, 1'b1, plain_result(KIND_REGMEM, 1'b0, 1'b0, MOD_REG, 3'd0, 3'd0, 8'h88));
    add_row(8'h8B);
    add_row(8'hFF, 1'b1, plain_result(KIND_REGMEM, 1'b1, 1'b1, MOD_REG, 3'd7, 3'd7, 8'h8B));
    // Byte displacement with the sign bit set.
    add_row(8'h8A);
    add_row(8'h46);
    add_row(8'h80);
    // Word displacement, low byte first.
    add_row(8'h89);
    add_row(8'h87);
    add_row(8'h34);
    add_row(8'h12);
    // Direct address: mode zero with rm 110 still takes two bytes.
    add_row(8'h8B);
    add_row(8'h36);
    add_row(8'hFF);
    add_row(8'hFF);
    add_row(8'h88);
    add_row(8'h00, 1'b1, plain_result(KIND_REGMEM, 1'b0, 1'b0, MOD_NODISP, 3'd0, 3'd0,
                                      8'h88));
    add_row(8'hB0);
    add_row(8'hFF);
    add_row(8'hBF);
    add_row(8'h00);
    add_row(8'h80);
    add_row(8'h8C, 1'b1, plain_result(KIND_UNKNOWN, 1'b0, 1'b0, 2'd0, 3'd0, 3'd0, 8'h8C));

    foreach (rows[i]) begin
      push_byte(rows[i].code, rows[i].typed, rows[i].want);
    end

    // Mostly whole instructions with random operands; the rest is stray bytes and
    // instructions cut short, whose successors then get eaten as operand bytes.
    while (bytes_sent < BYTES_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        lead  = {OP_REGMEM, 2'($urandom_range(3))};
        modrm = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) begin
          modrm[7:6] = MOD_NODISP;
          modrm[2:0] = RM_DIRECT;
        end
        stream_q.push_back(lead);
        stream_q.push_back(modrm);
        if (modrm[7:6] == MOD_DISP8) begin
          stream_q.push_back(8'($urandom_range(255)));
        end else if (modrm[7:6] == MOD_DISP16 || modrm[2:0] == RM_DIRECT &&
                     modrm[7:6] == MOD_NODISP) begin
          stream_q.push_back(8'($urandom_range(255)));
          stream_q.push_back(8'($urandom_range(255)));
        end
      end else if (pick < 80) begin
        lead = {OP_IMMREG, 4'($urandom_range(15))};
        stream_q.push_back(lead);
        stream_q.push_back(8'($urandom_range(255)));
        if (lead[3]) begin
          stream_q.push_back(8'($urandom_range(255)));
        end
      end else if (pick < 92) begin
        stream_q.push_back(8'($urandom_range(255)));
      end else if (pick < 96) begin
        stream_q.push_back({OP_REGMEM, 2'($urandom_range(3))});
      end else begin
        stream_q.push_back({OP_IMMREG, 4'($urandom_range(15))});
      end
      while (stream_q.size() != 0) begin
        push_byte(stream_q.pop_front(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d code bytes into %0d results: %0d register/memory, %0d immediate,",
             bytes_sent, results_seen, kind_seen[KIND_REGMEM], kind_seen[KIND_IMMREG]);
    $display("%0d unrecognized; %0d field mismatches.", kind_seen[KIND_UNKNOWN], errors);
    if (errors == 0) begin
      $display("mov_instruction_byte_decoder_core_tb passed");
    end else begin
      $display("mov_instruction_byte_decoder_core_tb failed");
    end
    $finish;
  end

endmodule
